[design/flha_pkg.sv]
// ----------------------------------------------------------------------------
// flha_pkg
// Shared types and constants of the free-list heap allocator.
// ----------------------------------------------------------------------------
package flha_pkg;

  localparam int unsigned AW         = 16;
  localparam int unsigned SZW        = 17;
  localparam int unsigned UW         = 18;
  localparam int unsigned STW        = 18;
  localparam int unsigned BYTES_W    = 21;
  localparam int unsigned UNIT_SHIFT = 4;
  localparam int unsigned HEAP_UNITS = 65536;

  localparam logic [STW-1:0] WALK_LIMIT = STW'(3 * HEAP_UNITS + 8);
  localparam logic [15:0]    MIN_GROW_RESET = 16'd10000;
  localparam logic [SZW-1:0] HEAP_TOP = SZW'(HEAP_UNITS);

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_A_INIT, S_A_GP, S_A_CHK, S_A_SPL, S_A_RES,
    S_I_INIT, S_I_CHK, S_I_B, S_I_MN, S_I_RDP, S_I_P, S_I_MP, S_I_END, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_START, CMD_A_INIT, CMD_A_GP, CMD_A_EXACT,
    CMD_A_SPLIT1, CMD_A_SPLIT2, CMD_A_NEXT, CMD_A_FAIL, CMD_A_RESUME, CMD_GROW,
    CMD_I_INIT, CMD_I_NEXT, CMD_I_BREAK, CMD_I_RDN, CMD_I_LINK, CMD_I_MN,
    CMD_I_RDP, CMD_I_RDSB, CMD_I_LINKP, CMD_I_MP, CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic over_limit;
    logic fits;
    logic exact;
    logic at_rover;
    logic grow_ok;
    logic ins_brk;
    logic step_over;
    logic merge_hi;
    logic merge_lo;
    logic out_busy;
  } status_t;

endpackage

[design/free_list_heap_allocator.sv]
// ----------------------------------------------------------------------------
// free_list_heap_allocator
// Next-fit allocator over a circular address-ordered free list in header memory.
// ----------------------------------------------------------------------------
// One item at a time. An allocate walks the free blocks from the rover; a grow
// adds an insertion walk to link the new arena block in. A free walks the list
// to the block's place and links it in. The walks are bound by the single read
// port of each header memory (link and size, each read data registered). The
// result register lets the next item enter while a finished result waits for
// transfer.
module free_list_heap_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [20:0] in_request_bytes,
  input  logic [15:0] in_block_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_addr,
  output logic        out_status,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import flha_pkg::*;

  cmd_t    cmd;
  status_t st;

  flha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  flha_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_func          (in_func),
    .in_request_bytes (in_request_bytes),
    .in_block_addr    (in_block_addr),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_addr         (out_addr),
    .out_status       (out_status)
  );

endmodule

[design/flha_ctrl.sv]
// ----------------------------------------------------------------------------
// flha_ctrl
// Sequencer for allocate walks, arena growth and address-ordered insertion.
// ----------------------------------------------------------------------------
module flha_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  flha_pkg::status_t st,
  output flha_pkg::cmd_t   cmd
);
  import flha_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_START;
      S_START:  state_nxt = st.is_free ? S_I_INIT : S_A_INIT;
      S_A_INIT: state_nxt = S_A_GP;
      S_A_GP:   state_nxt = S_A_CHK;
      S_A_CHK: begin
        if (st.over_limit) state_nxt = S_DONE;
        else if (st.fits) state_nxt = st.exact ? S_DONE : S_A_SPL;
        else if (st.at_rover) state_nxt = st.grow_ok ? S_I_INIT : S_DONE;
        else state_nxt = S_A_CHK;
      end
      S_A_SPL:  state_nxt = S_DONE;
      S_A_RES:  state_nxt = S_A_GP;
      S_I_INIT: state_nxt = S_I_CHK;
      S_I_CHK: begin
        if (st.ins_brk) state_nxt = S_I_B;
        else if (st.step_over) state_nxt = S_I_END;
        else state_nxt = S_I_CHK;
      end
      S_I_B:    state_nxt = st.merge_hi ? S_I_MN : S_I_RDP;
      S_I_MN:   state_nxt = S_I_RDP;
      S_I_RDP:  state_nxt = S_I_P;
      S_I_P:    state_nxt = st.merge_lo ? S_I_MP : S_I_END;
      S_I_MP:   state_nxt = S_I_END;
      S_I_END:  state_nxt = st.is_free ? S_DONE : S_A_RES;
      S_DONE:   if (!st.out_busy) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = CMD_NONE;
    unique case (state_r)
      S_IDLE:   if (in_valid) cmd = CMD_LOAD;
      S_START:  cmd = CMD_START;
      S_A_INIT: cmd = CMD_A_INIT;
      S_A_GP:   cmd = CMD_A_GP;
      S_A_CHK: begin
        if (st.over_limit) cmd = CMD_A_FAIL;
        else if (st.fits) cmd = st.exact ? CMD_A_EXACT : CMD_A_SPLIT1;
        else if (st.at_rover) cmd = st.grow_ok ? CMD_GROW : CMD_A_FAIL;
        else cmd = CMD_A_NEXT;
      end
      S_A_SPL:  cmd = CMD_A_SPLIT2;
      S_A_RES:  cmd = CMD_A_RESUME;
      S_I_INIT: cmd = CMD_I_INIT;
      S_I_CHK: begin
        if (st.ins_brk) cmd = CMD_I_BREAK;
        else if (!st.step_over) cmd = CMD_I_NEXT;
      end
      S_I_B:    cmd = st.merge_hi ? CMD_I_RDN : CMD_I_LINK;
      S_I_MN:   cmd = CMD_I_MN;
      S_I_RDP:  cmd = CMD_I_RDP;
      S_I_P:    cmd = st.merge_lo ? CMD_I_RDSB : CMD_I_LINKP;
      S_I_MP:   cmd = CMD_I_MP;
      S_I_END:  cmd = CMD_NONE;
      S_DONE:   if (!st.out_busy) cmd = CMD_EMIT;
      default:  cmd = CMD_NONE;
    endcase
  end

endmodule

[design/flha_dp.sv]
// ----------------------------------------------------------------------------
// flha_dp
// Header memories (link and size), walk pointers, arena break and result register.
// ----------------------------------------------------------------------------
module flha_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  flha_pkg::cmd_t            cmd,
  output flha_pkg::status_t         st,
  input  logic                      in_func,
  input  logic [20:0]               in_request_bytes,
  input  logic [15:0]               in_block_addr,
  input  logic                      cfg_we,
  input  logic [15:0]               cfg_wdata,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [15:0]               out_addr,
  output logic                      out_status
);
  import flha_pkg::*;

  logic [AW-1:0]  nxt_mem [HEAP_UNITS];
  logic [SZW-1:0] siz_mem [HEAP_UNITS];

  logic [AW-1:0]  qn, n_raddr, n_waddr, n_wdata;
  logic [SZW-1:0] qs, s_wdata;
  logic [AW-1:0]  s_raddr, s_waddr;
  logic           n_we, s_we;

  logic           func_r, func_nxt;
  logic [UW-1:0]  units_r, units_nxt;
  logic [AW-1:0]  bp_r, bp_nxt, p_r, p_nxt, prevp_r, prevp_nxt, n_r, n_nxt;
  logic [AW-1:0]  rover_r, rover_nxt, lnk_r, lnk_nxt;
  logic [SZW-1:0] sz_r, sz_nxt, brk_r, brk_nxt;
  logic [STW-1:0] sta_r, sta_nxt, sti_r, sti_nxt;
  logic           started_r, started_nxt;
  logic [15:0]    min_grow_r, min_grow_nxt;
  logic [AW-1:0]  res_addr_r, res_addr_nxt;
  logic           res_stat_r, res_stat_nxt;
  logic           ov_r, ov_nxt;
  logic [AW-1:0]  oa_r, oa_nxt;
  logic           os_r, os_nxt;

  logic [UW-1:0]  nu;
  logic [SZW-1:0] room, split_sz;
  logic [AW-1:0]  split_p;
  logic [21:0]    byte_sum;

  always_ff @(posedge clk) begin
    if (n_we) nxt_mem[n_waddr] <= n_wdata;
    if (s_we) siz_mem[s_waddr] <= s_wdata;
    qn <= nxt_mem[n_raddr];
    qs <= siz_mem[s_raddr];
  end

  assign byte_sum = {1'b0, in_request_bytes} + 22'd15;
  assign nu       = (units_r > {2'b0, min_grow_r}) ? units_r : {2'b0, min_grow_r};
  assign room     = HEAP_TOP - brk_r;
  assign split_sz = qs - units_r[SZW-1:0];
  assign split_p  = p_r + sz_r[AW-1:0];

  always_comb begin
    st.is_free    = func_r;
    st.over_limit = sta_r > WALK_LIMIT;
    st.fits       = {1'b0, qs} >= units_r;
    st.exact      = {1'b0, qs} == units_r;
    st.at_rover   = p_r == rover_r;
    st.grow_ok    = !brk_r[SZW-1] && (nu <= {1'b0, room});
    st.ins_brk    = (bp_r > p_r && bp_r < qn) || (p_r >= qn && (bp_r > p_r || bp_r < qn));
    st.step_over  = (sti_r + STW'(1)) > WALK_LIMIT;
    st.merge_hi   = ({2'b0, bp_r} + {1'b0, qs}) == {2'b0, n_r};
    st.merge_lo   = ({2'b0, p_r} + {1'b0, qs}) == {2'b0, bp_r};
    st.out_busy   = ov_r && !out_ready;
  end

  always_comb begin
    func_nxt = func_r; units_nxt = units_r; bp_nxt = bp_r; p_nxt = p_r;
    prevp_nxt = prevp_r; n_nxt = n_r; rover_nxt = rover_r; lnk_nxt = lnk_r;
    sz_nxt = sz_r; brk_nxt = brk_r; sta_nxt = sta_r; sti_nxt = sti_r;
    started_nxt = started_r; res_addr_nxt = res_addr_r; res_stat_nxt = res_stat_r;
    min_grow_nxt = cfg_we ? cfg_wdata : min_grow_r;
    ov_nxt = ov_r && !out_ready; oa_nxt = oa_r; os_nxt = os_r;
    n_raddr = p_r; s_raddr = p_r;
    n_we = 1'b0; n_waddr = p_r; n_wdata = '0;
    s_we = 1'b0; s_waddr = p_r; s_wdata = '0;
    unique case (cmd)
      CMD_NONE: ;
      CMD_LOAD: begin
        func_nxt     = in_func;
        units_nxt    = byte_sum[21:UNIT_SHIFT] + UW'(1);
        bp_nxt       = in_block_addr - AW'(1);
        res_addr_nxt = '0;
        res_stat_nxt = 1'b0;
      end
      CMD_START: begin
        if (!started_r) begin
          n_we = 1'b1; n_waddr = '0; n_wdata = '0;
          s_we = 1'b1; s_waddr = '0; s_wdata = '0;
          rover_nxt = '0;
          started_nxt = 1'b1;
        end
      end
      CMD_A_INIT: begin
        n_raddr = rover_r; prevp_nxt = rover_r; sta_nxt = '0;
      end
      CMD_A_GP: begin
        p_nxt = qn; n_raddr = qn; s_raddr = qn;
      end
      CMD_A_EXACT: begin
        n_we = 1'b1; n_waddr = prevp_r; n_wdata = qn;
        rover_nxt = prevp_r;
        res_addr_nxt = p_r + AW'(1);
      end
      CMD_A_SPLIT1: begin
        s_we = 1'b1; s_waddr = p_r; s_wdata = split_sz;
        sz_nxt = split_sz;
      end
      CMD_A_SPLIT2: begin
        s_we = 1'b1; s_waddr = split_p; s_wdata = units_r[SZW-1:0];
        rover_nxt = prevp_r;
        res_addr_nxt = split_p + AW'(1);
      end
      CMD_A_NEXT: begin
        prevp_nxt = p_r; p_nxt = qn; sta_nxt = sta_r + STW'(1);
        n_raddr = qn; s_raddr = qn;
      end
      CMD_A_FAIL: begin
        res_addr_nxt = '0; res_stat_nxt = 1'b1;
      end
      CMD_A_RESUME: begin
        n_raddr = rover_r; prevp_nxt = rover_r; sta_nxt = sta_r + STW'(1);
      end
      CMD_GROW: begin
        s_we = 1'b1; s_waddr = brk_r[AW-1:0]; s_wdata = nu[SZW-1:0];
        bp_nxt = brk_r[AW-1:0];
        brk_nxt = brk_r + nu[SZW-1:0];
      end
      CMD_I_INIT: begin
        p_nxt = rover_r; sti_nxt = '0; n_raddr = rover_r;
      end
      CMD_I_NEXT: begin
        p_nxt = qn; sti_nxt = sti_r + STW'(1); n_raddr = qn;
      end
      CMD_I_BREAK: begin
        n_nxt = qn; s_raddr = bp_r;
      end
      CMD_I_RDN: begin
        sz_nxt = qs; n_raddr = n_r; s_raddr = n_r;
      end
      CMD_I_LINK: begin
        n_we = 1'b1; n_waddr = bp_r; n_wdata = n_r;
      end
      CMD_I_MN: begin
        s_we = 1'b1; s_waddr = bp_r; s_wdata = sz_r + qs;
        n_we = 1'b1; n_waddr = bp_r; n_wdata = qn;
      end
      CMD_I_RDP: begin
        s_raddr = p_r; n_raddr = bp_r;
      end
      CMD_I_RDSB: begin
        sz_nxt = qs; lnk_nxt = qn; s_raddr = bp_r;
      end
      CMD_I_LINKP: begin
        n_we = 1'b1; n_waddr = p_r; n_wdata = bp_r;
        rover_nxt = p_r;
      end
      CMD_I_MP: begin
        s_we = 1'b1; s_waddr = p_r; s_wdata = sz_r + qs;
        n_we = 1'b1; n_waddr = p_r; n_wdata = lnk_r;
        rover_nxt = p_r;
      end
      CMD_EMIT: begin
        ov_nxt = 1'b1; oa_nxt = res_addr_r; os_nxt = res_stat_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rover_r    <= '0;
      started_r  <= 1'b0;
      brk_r      <= SZW'(1);
      min_grow_r <= MIN_GROW_RESET;
      ov_r       <= 1'b0;
    end else begin
      rover_r    <= rover_nxt;
      started_r  <= started_nxt;
      brk_r      <= brk_nxt;
      min_grow_r <= min_grow_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt; units_r <= units_nxt; bp_r <= bp_nxt; p_r <= p_nxt;
    prevp_r <= prevp_nxt; n_r <= n_nxt; lnk_r <= lnk_nxt; sz_r <= sz_nxt;
    sta_r <= sta_nxt; sti_r <= sti_nxt;
    res_addr_r <= res_addr_nxt; res_stat_r <= res_stat_nxt;
    oa_r <= oa_nxt; os_r <= os_nxt;
  end

  assign out_valid  = ov_r;
  assign out_addr   = oa_r;
  assign out_status = os_r;

endmodule
